[hw/rtl/bar_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_pkg: shared types and constants for button auto-repeat
// Widths, register indexes, reset values and memory request structs.
// ----------------------------------------------------------------------------
package bar_pkg;

  localparam int BTN_W     = 16;  // button word width
  localparam int BIDX_W    = 4;   // button bit index
  localparam int CTL_W     = 2;   // controller index
  localparam int CTL_SLOTS = 4;   // enable masks in the register file
  localparam int CNT_W     = 16;  // hold counter width
  localparam int CFG_IDX_W = 3;
  localparam int CFG_W     = 16;

  localparam int NUM_CONTROLLERS_DEF = 4;
  localparam int NUM_BUTTONS_DEF     = 16;

  localparam logic [CNT_W-1:0] DELAY_RST  = 16'h0014;
  localparam logic [CNT_W-1:0] PERIOD_RST = 16'd4;

  // remainder unit: bits retired per cycle and cycles per operation
  localparam int REM_BITS_PER_CYC = 4;
  localparam int REM_CYCLES       = CNT_W / REM_BITS_PER_CYC;
  localparam int REM_STEP_W       = $clog2(REM_CYCLES);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DELAY  = 3'd0,
    CFG_PERIOD = 3'd1,
    CFG_MASK0  = 3'd2,
    CFG_MASK1  = 3'd3,
    CFG_MASK2  = 3'd4,
    CFG_MASK3  = 3'd5
  } cfg_idx_e;

  typedef enum logic {
    ACT_SAMPLE = 1'b0,
    ACT_FAST   = 1'b1
  } action_e;

  typedef struct packed {
    logic              en;
    logic [CTL_W-1:0]  ctl;
    logic [BIDX_W-1:0] btn;
  } cnt_rd_t;

  typedef struct packed {
    logic              en;
    logic [CTL_W-1:0]  ctl;
    logic [BIDX_W-1:0] btn;
    logic [CNT_W-1:0]  data;
  } cnt_wr_t;

endpackage

[hw/rtl/bar_in_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_in_if: request channel into the auto-repeat block
// Valid/ready handshake carrying action, controller and button word.
// ----------------------------------------------------------------------------
interface bar_in_if;
  import bar_pkg::*;

  logic             valid;
  logic             ready;
  logic             action;
  logic [CTL_W-1:0] controller;
  logic [BTN_W-1:0] buttons;

  modport source (output valid, output action, output controller, output buttons,
                  input ready);
  modport sink   (input valid, input action, input controller, input buttons,
                  output ready);
endinterface

[hw/rtl/bar_out_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_out_if: result channel out of the auto-repeat block
// Valid/ready handshake carrying pressed and repeat bits.
// ----------------------------------------------------------------------------
interface bar_out_if;
  import bar_pkg::*;

  logic             valid;
  logic             ready;
  logic [BTN_W-1:0] pressed;
  logic [BTN_W-1:0] repeat_res;

  modport source (output valid, output pressed, output repeat_res, input ready);
  modport sink   (input valid, input pressed, input repeat_res, output ready);
endinterface

[hw/rtl/bar_cnt_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_cnt_mem: hold counter memory
// One write and one read port, registered read data, per-entry valid bits
// so that entries read as zero until written after reset.
// ----------------------------------------------------------------------------
module bar_cnt_mem #(
  parameter int NUM_CONTROLLERS = bar_pkg::NUM_CONTROLLERS_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  bar_pkg::cnt_rd_t            rd_i,
  input  bar_pkg::cnt_wr_t            wr_i,
  output logic [bar_pkg::CNT_W-1:0]   rdata_o
);
  import bar_pkg::*;

  localparam int Depth = NUM_CONTROLLERS * BTN_W;
  localparam int AW    = $clog2(Depth);

  logic [CNT_W-1:0] mem [Depth];
  logic [Depth-1:0] vld_q;
  logic [CNT_W-1:0] rdata_q;
  logic             rvld_q;
  logic [AW-1:0]    raddr, waddr;

  assign raddr = AW'({rd_i.ctl, rd_i.btn});
  assign waddr = AW'({wr_i.ctl, wr_i.btn});

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[waddr] <= wr_i.data;
    end
    if (rd_i.en) begin
      rdata_q <= mem[raddr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q  <= '0;
      rvld_q <= 1'b0;
    end else begin
      if (wr_i.en) begin
        vld_q[waddr] <= 1'b1;
      end
      if (rd_i.en) begin
        rvld_q <= vld_q[raddr];
      end
    end
  end

  assign rdata_o = rvld_q ? rdata_q : '0;

endmodule

[hw/rtl/bar_rem_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bar_rem_unit: iterative remainder
// Restoring division, a few bits per cycle; flags a zero remainder.
// ----------------------------------------------------------------------------
module bar_rem_unit (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [bar_pkg::CNT_W-1:0] dividend_i,
  input  logic [bar_pkg::CNT_W-1:0] divisor_i,
  output logic                      done_o,
  output logic                      zero_o
);
  import bar_pkg::*;

  logic                  busy_q;
  logic [REM_STEP_W-1:0] step_q;
  logic [CNT_W-1:0]      num_q, num_d;
  logic [CNT_W-1:0]      rem_q, rem_d;
  logic [CNT_W-1:0]      div_q;

  always_comb begin
    logic [CNT_W:0] r;
    r     = {1'b0, rem_q};
    num_d = num_q;
    for (int i = 0; i < REM_BITS_PER_CYC; i++) begin
      r     = {r[CNT_W-1:0], num_d[CNT_W-1]};
      num_d = {num_d[CNT_W-2:0], 1'b0};
      if (r >= {1'b0, div_q}) begin
        r = r - {1'b0, div_q};
      end
    end
    rem_d = r[CNT_W-1:0];
  end

  assign done_o = busy_q && (step_q == REM_STEP_W'(REM_CYCLES - 1));
  assign zero_o = (rem_d == '0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      step_q <= step_q + 1'b1;
      if (done_o) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= dividend_i;
      rem_q <= '0;
      div_q <= divisor_i;
    end else if (busy_q) begin
      num_q <= num_d;
      rem_q <= rem_d;
    end
  end

endmodule

[hw/rtl/button_auto_repeat_core.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_auto_repeat_core: typematic auto-repeat for game controller buttons
// Tracks newly pressed buttons and per-button hold counters kept in memory.
// ----------------------------------------------------------------------------
// Fast-set items pass ST_FAST then ST_DONE; out-of-range items go to ST_DONE.
// Sample items walk the covered buttons serially: a disabled button takes a
//   ST_READ step, an enabled one ST_READ then ST_CALC, and a held enabled button
//   at or past the delay also waits in ST_DIV, except at count 1 or zero period.
// The walk reads the counter memory once per enabled button, and ST_DIV uses
// the 4-bit-per-cycle remainder unit.
// One item in flight; the next is taken while a result waits in the output reg.
// Reset: asynchronous, active low; all counters and held words read as zero.
// ----------------------------------------------------------------------------
module button_auto_repeat_core #(
  parameter int NUM_CONTROLLERS = bar_pkg::NUM_CONTROLLERS_DEF,
  parameter int NUM_BUTTONS     = bar_pkg::NUM_BUTTONS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bar_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [bar_pkg::CFG_W-1:0]     cfg_wdata_i,
  bar_in_if.sink                        in_if,
  bar_out_if.source                     out_if
);
  import bar_pkg::*;

  // Covered buttons are the top NUM_BUTTONS bits of the word.
  localparam logic [BIDX_W-1:0] BtnLo  = BIDX_W'(BTN_W - NUM_BUTTONS);
  localparam logic [BIDX_W-1:0] BtnHi  = BIDX_W'(BTN_W - 1);
  localparam logic [BTN_W-1:0]  CovMsk = {BTN_W{1'b1}} << (BTN_W - NUM_BUTTONS);

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_FAST = 6'b000010,
    ST_READ = 6'b000100,
    ST_CALC = 6'b001000,
    ST_DIV  = 6'b010000,
    ST_DONE = 6'b100000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [CNT_W-1:0] delay_q, period_q;
  logic [BTN_W-1:0] mask_q [CTL_SLOTS];
  logic [CTL_W-1:0] cfg_mask_sel;

  // per-controller last held word (few entries, kept in flops)
  logic [BTN_W-1:0] prev_q [NUM_CONTROLLERS];
  logic [BTN_W-1:0] prev_sel;

  // current request context
  logic             act_q;
  logic [CTL_W-1:0] ctl_q;
  logic [BTN_W-1:0] word_q, en_q;
  logic [BTN_W-1:0] pressed_q, pressed_d;
  logic [BTN_W-1:0] rep_q, rep_d;
  logic [BIDX_W-1:0] bidx_q, bidx_d;

  // output register
  logic             out_vld_q, out_vld_d;
  logic [BTN_W-1:0] out_pressed_q, out_rep_q;

  logic in_acc, ctl_ok, load_out, last_btn;
  logic [BTN_W-1:0] bit_m;

  // memory and remainder hookup
  cnt_rd_t          rd;
  cnt_wr_t          wr;
  logic [CNT_W-1:0] cnt_rd, cnt_new, over;
  logic             rem_start, rem_done, rem_zero;

  // fast-set search
  logic [BTN_W-1:0]  fs_m;
  logic              fs_hit;
  logic [BIDX_W-1:0] fs_idx;

  bar_cnt_mem #(
    .NUM_CONTROLLERS(NUM_CONTROLLERS)
  ) u_cnt_mem (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .rd_i   (rd),
    .wr_i   (wr),
    .rdata_o(cnt_rd)
  );

  bar_rem_unit u_rem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (rem_start),
    .dividend_i(over),
    .divisor_i (period_q),
    .done_o    (rem_done),
    .zero_o    (rem_zero)
  );

  // ---------------------------------------------------------------- config
  assign cfg_mask_sel = CTL_W'(cfg_idx_i - CFG_MASK0);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delay_q  <= DELAY_RST;
      period_q <= PERIOD_RST;
      for (int i = 0; i < CTL_SLOTS; i++) begin
        mask_q[i] <= '0;
      end
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DELAY:  delay_q  <= cfg_wdata_i;
        CFG_PERIOD: period_q <= cfg_wdata_i;
        default: begin
          if (cfg_idx_i inside {[CFG_MASK0:CFG_MASK3]}) begin
            mask_q[cfg_mask_sel] <= cfg_wdata_i;
          end
        end
      endcase
    end
  end

  // ---------------------------------------------------------------- intake
  assign in_if.ready = (state_q == ST_IDLE);
  assign in_acc      = in_if.valid && in_if.ready;
  assign ctl_ok      = {1'b0, in_if.controller} < (CTL_W + 1)'(NUM_CONTROLLERS);

  always_comb begin
    prev_sel = '0;
    for (int i = 0; i < NUM_CONTROLLERS; i++) begin
      if (in_if.controller == CTL_W'(i)) begin
        prev_sel = prev_q[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NUM_CONTROLLERS; i++) begin
        prev_q[i] <= '0;
      end
    end else if (in_acc && ctl_ok && (in_if.action == ACT_SAMPLE)) begin
      for (int i = 0; i < NUM_CONTROLLERS; i++) begin
        if (in_if.controller == CTL_W'(i)) begin
          prev_q[i] <= in_if.buttons;
        end
      end
    end
  end

  // ---------------------------------------------------------------- datapath
  assign bit_m    = BTN_W'(1) << bidx_q;
  assign last_btn = (bidx_q == BtnHi);
  assign cnt_new  = cnt_rd + 1'b1;
  assign over     = cnt_new - delay_q;

  // lowest covered set bit for fast-set
  always_comb begin
    fs_m   = word_q & CovMsk;
    fs_hit = 1'b0;
    fs_idx = '0;
    for (int i = BTN_W - 1; i >= 0; i--) begin
      if (fs_m[i]) begin
        fs_hit = 1'b1;
        fs_idx = BIDX_W'(i);
      end
    end
  end

  assign load_out = (state_q == ST_DONE) && (!out_vld_q || out_if.ready);

  always_comb begin
    state_d   = state_q;
    pressed_d = pressed_q;
    rep_d     = rep_q;
    bidx_d    = bidx_q;
    rd        = '0;
    wr        = '0;
    rem_start = 1'b0;

    case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          pressed_d = '0;
          rep_d     = '0;
          bidx_d    = BtnLo;
          if (!ctl_ok) begin
            state_d = ST_DONE;
          end else if (in_if.action == ACT_FAST) begin
            state_d = ST_FAST;
          end else begin
            pressed_d = in_if.buttons & ~prev_sel;
            state_d   = ST_READ;
          end
        end
      end
      ST_FAST: begin
        wr.en   = fs_hit;
        wr.ctl  = ctl_q;
        wr.btn  = fs_idx;
        wr.data = delay_q + period_q - 1'b1;
        state_d = ST_DONE;
      end
      ST_READ: begin
        if (en_q[bidx_q]) begin
          rd.en   = 1'b1;
          rd.ctl  = ctl_q;
          rd.btn  = bidx_q;
          state_d = ST_CALC;
        end else if (last_btn) begin
          state_d = ST_DONE;
        end else begin
          bidx_d = bidx_q + 1'b1;
        end
      end
      ST_CALC: begin
        wr.en   = 1'b1;
        wr.ctl  = ctl_q;
        wr.btn  = bidx_q;
        wr.data = word_q[bidx_q] ? cnt_new : '0;
        state_d = last_btn ? ST_DONE : ST_READ;
        bidx_d  = last_btn ? bidx_q : bidx_q + 1'b1;
        if (word_q[bidx_q]) begin
          if (cnt_new == CNT_W'(1)) begin
            rep_d = rep_q | bit_m;
          end else if (cnt_new >= delay_q) begin
            if (period_q == '0) begin
              // zero period: fires only exactly at the delay
              if (over == '0) begin
                rep_d = rep_q | bit_m;
              end
            end else begin
              rem_start = 1'b1;
              bidx_d    = bidx_q;
              state_d   = ST_DIV;
            end
          end
        end
      end
      ST_DIV: begin
        if (rem_done) begin
          if (rem_zero) begin
            rep_d = rep_q | bit_m;
          end
          state_d = last_btn ? ST_DONE : ST_READ;
          bidx_d  = last_btn ? bidx_q : bidx_q + 1'b1;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    out_vld_d = out_vld_q;
    if (out_if.ready) begin
      out_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pressed_q <= pressed_d;
    rep_q     <= rep_d;
    bidx_q    <= bidx_d;
    if (in_acc) begin
      act_q  <= in_if.action;
      ctl_q  <= in_if.controller;
      word_q <= in_if.buttons;
      en_q   <= mask_q[in_if.controller] & CovMsk;
    end
    if (load_out) begin
      // fast-set and out-of-range items leave zeros from intake
      out_pressed_q <= (act_q == ACT_SAMPLE) ? pressed_q : '0;
      out_rep_q     <= rep_q;
    end
  end

  assign out_if.valid      = out_vld_q;
  assign out_if.pressed    = out_pressed_q;
  assign out_if.repeat_res = out_rep_q;

endmodule
